// ----- design/ace_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ace_pkg;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_M        = 8'h6D;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] PARAM_MAX   = 8'd255;
   localparam logic [7:0] BASE_COLOR_RESET = 8'h07;

   localparam logic [7:0] FG_LO    = 8'd30;
   localparam logic [7:0] FG_HI    = 8'd37;
   localparam logic [7:0] FG_BR_LO = 8'd90;
   localparam logic [7:0] FG_BR_HI = 8'd97;
   localparam logic [7:0] BG_LO    = 8'd40;
   localparam logic [7:0] BG_HI    = 8'd47;
   localparam logic [7:0] BG_BR_LO = 8'd100;
   localparam logic [7:0] BG_BR_HI = 8'd107;

   localparam logic       KIND_CHAR  = 1'b0;
   localparam logic       KIND_COLOR = 1'b1;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_SEQ    = 2'd2,
      MODE_RAW    = 2'd3
   } parse_mode_type;

   typedef struct packed {
      parse_mode_type mode;
      logic [7:0]     param_value;
      logic           digits_seen;
      logic [3:0]     pending_fg;
      logic [3:0]     pending_bg;
   } parse_state_type;

   typedef struct packed {
      logic       emit;
      logic       kind;
      logic [7:0] char_out;
      logic [3:0] fg_color;
      logic [3:0] bg_color;
   } result_type;

   typedef struct packed {
      logic [3:0] fg;
      logic [3:0] bg;
   } color_pair_type;

   // Fold one finished SGR code into the pending colors; unknown codes leave them.
   function automatic color_pair_type apply_code(input logic [7:0] n,
                                                 input color_pair_type cur);
      color_pair_type res;
      logic [7:0]     diff;
      res  = cur;
      diff = 8'd0;
      if (n inside {[FG_LO:FG_HI]}) begin
         diff   = n - FG_LO;
         res.fg = diff[3:0];
      end else if (n inside {[FG_BR_LO:FG_BR_HI]}) begin
         diff   = n - FG_BR_LO + 8'd8;
         res.fg = diff[3:0];
      end else if (n inside {[BG_LO:BG_HI]}) begin
         diff   = n - BG_LO;
         res.bg = diff[3:0];
      end else if (n inside {[BG_BR_LO:BG_BR_HI]}) begin
         diff   = n - BG_BR_LO + 8'd8;
         res.bg = diff[3:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/ace_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ace_parser import ace_pkg::*; (
   input  wire parse_state_type state,
   input  wire logic [7:0]      char_code,
   input  wire logic            end_of_text,
   input  wire logic [7:0]      base_color,
   output parse_state_type      next_state,
   output result_type           result
);

   color_pair_type cur_pair;
   color_pair_type new_pair;
   logic [11:0]    acc_wide;
   logic [7:0]     digit;

   assign cur_pair = '{fg: state.pending_fg, bg: state.pending_bg};
   assign new_pair = apply_code(state.param_value, cur_pair);
   assign digit    = char_code - CH_ZERO;
   // value * 10 + digit as shifts, wide enough not to wrap before saturation
   assign acc_wide = {1'b0, state.param_value, 3'b000}
                   + {3'b000, state.param_value, 1'b0}
                   + {8'd0, digit[3:0]};

   always_comb begin
      next_state      = state;
      result.emit     = 1'b0;
      result.kind     = KIND_CHAR;
      result.char_out = char_code;
      result.fg_color = 4'd0;
      result.bg_color = 4'd0;

      case (state.mode)
         MODE_NORMAL: begin
            if (char_code == CH_ESC) begin
               next_state.mode = MODE_ESC;
            end else begin
               result.emit = 1'b1;
            end
         end
         MODE_ESC: begin
            if (char_code == CH_LBRACKET) begin
               next_state.mode        = MODE_SEQ;
               next_state.param_value = 8'd0;
               next_state.digits_seen = 1'b0;
               next_state.pending_fg  = base_color[3:0];
               next_state.pending_bg  = base_color[7:4];
            end else begin
               next_state.mode = MODE_NORMAL;
               result.emit     = 1'b1;
            end
         end
         MODE_SEQ: begin
            if (char_code inside {[CH_ZERO:CH_NINE]}) begin
               next_state.param_value = (acc_wide > 12'(PARAM_MAX)) ? PARAM_MAX
                                                                    : acc_wide[7:0];
               next_state.digits_seen = 1'b1;
            end else if (char_code == CH_SEMI) begin
               next_state.pending_fg  = new_pair.fg;
               next_state.pending_bg  = new_pair.bg;
               next_state.param_value = 8'd0;
               next_state.digits_seen = 1'b0;
            end else if (char_code == CH_M) begin
               if (state.digits_seen) begin
                  next_state.pending_fg = new_pair.fg;
                  next_state.pending_bg = new_pair.bg;
                  next_state.mode       = MODE_NORMAL;
                  result.emit           = 1'b1;
                  result.kind           = KIND_COLOR;
                  result.char_out       = 8'd0;
                  result.fg_color       = new_pair.fg;
                  result.bg_color       = new_pair.bg;
               end else begin
                  next_state.mode = MODE_RAW;
               end
               next_state.param_value = 8'd0;
               next_state.digits_seen = 1'b0;
            end
         end
         default: begin
            next_state.mode = MODE_NORMAL;
            result.emit     = 1'b1;
         end
      endcase

      // drop anything left open at the end of the text
      if (end_of_text) begin
         next_state.mode        = MODE_NORMAL;
         next_state.param_value = 8'd0;
         next_state.digits_seen = 1'b0;
         next_state.pending_fg  = 4'd0;
         next_state.pending_bg  = 4'd0;
      end
   end

endmodule

`default_nettype wire

// ----- design/ansi_color_escape_filter.sv -----
// An accepted word waits in the input register, passes the parser and is registered
// in the result register for rsp_. Throughput: one word per cycle while rsp_stall is
// low; input register and parser state update together, result register holds one word.
// Reset (synchronous, active high): parser back to normal mode, pending colors and
// accumulator cleared, base color set to 7, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module ansi_color_escape_filter import ace_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   // input character stream
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_end_of_text,
   // display command stream
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic [7:0]      rsp_char_out,
   output logic [3:0]      rsp_fg_color,
   output logic [3:0]      rsp_bg_color,
   // base color register
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   // Base color register: low nibble foreground, high nibble background.
   logic [7:0] base_color_ff;

   // Input register: one captured word waiting for the parser.
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // Parser state, updated only when the captured word advances.
   parse_state_type state_ff;
   parse_state_type state_in;

   // Result register.
   result_type result_in;
   logic       out_valid_ff;
   logic       out_kind_ff;
   logic [7:0] out_char_ff;
   logic [3:0] out_fg_ff;
   logic [3:0] out_bg_ff;

   logic out_free;
   logic advance;
   logic in_load;

   // The result register can take a word when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   // The captured word moves through the parser when the result side has room.
   assign advance   = in_valid_ff && out_free;
   // Refill the input register whenever it is empty or emptying.
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   ace_parser u_parser (
      .state       (state_ff),
      .char_code   (in_char_ff),
      .end_of_text (in_last_ff),
      .base_color  (base_color_ff),
      .next_state  (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_color_ff <= BASE_COLOR_RESET;
      end else if (csr_wr_en) begin
         base_color_ff <= csr_wr_data;
      end
   end

   // Input stage: hold while the parser cannot advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_end_of_text;
      end
   end

   // Parser state: advance with each consumed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_NORMAL, param_value: 8'd0, digits_seen: 1'b0,
                       pending_fg: 4'd0, pending_bg: 4'd0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result stage: a consumed word that produces nothing leaves the register empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && result_in.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && out_free) begin
         out_kind_ff <= result_in.kind;
         out_char_ff <= result_in.char_out;
         out_fg_ff   <= result_in.fg_color;
         out_bg_ff   <= result_in.bg_color;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_fg_color = out_fg_ff;
   assign rsp_bg_color = out_bg_ff;

endmodule

`default_nettype wire
